@@ hdl/mwe_pkg.sv @@
package mwe_pkg;

    localparam int ADDR_BITS = 9;
    localparam int DATA_BITS = 16;
    localparam int MAX_BURST = 512;

    localparam int LEN_W     = 10;
    localparam int POLL_W    = 16;
    localparam int BURST_W   = $clog2(MAX_BURST + 1);
    localparam int FRAME_W   = ADDR_BITS + 4 + DATA_BITS;
    localparam int CNT_W     = $clog2(FRAME_W);

    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = POLL_W'(5000);

    localparam logic REG_POLL_LIMIT = 1'b0;
    localparam logic REG_AUTO_WE    = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_REJECT  = 2'd2;

    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_ERASE = 2'b11;

    localparam logic [FRAME_W-1:0] START_BIT = FRAME_W'(1) << (ADDR_BITS + 3);
    localparam logic [FRAME_W-1:0] FILL_ONES =
        (FRAME_W'(1) << (ADDR_BITS - 1)) - FRAME_W'(1);
    localparam logic [FRAME_W-1:0] EN_FRAME  =
        START_BIT | (FRAME_W'(3) << (ADDR_BITS - 1)) | FILL_ONES;
    localparam logic [FRAME_W-1:0] DIS_FRAME = START_BIT | FILL_ONES;

    localparam logic [CNT_W-1:0] SHORT_CNT = CNT_W'(ADDR_BITS + 3);
    localparam logic [CNT_W-1:0] LONG_CNT  = CNT_W'(ADDR_BITS + 3 + DATA_BITS);
    localparam logic [CNT_W-1:0] READ_CNT  = CNT_W'(DATA_BITS - 1);

    typedef enum logic [2:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_ERASE   = 3'd2,
        CMD_ENABLE  = 3'd3,
        CMD_DISABLE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_EN_BITS  = 4'd1,
        PH_EN_GAP   = 4'd2,
        PH_OP_BITS  = 4'd3,
        PH_READ     = 4'd4,
        PH_OP_GAP   = 4'd5,
        PH_POLL     = 4'd6,
        PH_POLL_GAP = 4'd7,
        PH_DIS_BITS = 4'd8,
        PH_DONE_GAP = 4'd9
    } phase_t;

    typedef struct packed {
        kind_t                kind;
        cmd_t                 cmd;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] data;
        logic [BURST_W-1:0]   len;
        logic                 pin;
    } item_t;

    typedef struct packed {
        logic                 sel;
        logic                 di;
        logic                 clk;
        logic [DATA_BITS-1:0] word;
        logic                 valid;
        logic                 done;
        logic [1:0]           status;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic [POLL_W-1:0] poll_limit;
        logic              auto_we;
    } cfg_t;

endpackage

@@ hdl/mwe_front.sv @@
module mwe_front
    import mwe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 req_type,
    input  logic [2:0]           command,
    input  logic [8:0]           word_address,
    input  logic [15:0]          write_word,
    input  logic [LEN_W-1:0]     burst_length,
    input  logic                 serial_in_pin,
    output logic                 item_valid,
    output item_t                item,
    input  logic                 item_take
);

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    item_t      dec;
    logic       wr_en;
    logic       rd_en;

    // classify and normalize the incoming word
    always_comb
    begin
        dec      = '0;
        dec.addr = ADDR_BITS'(word_address);
        dec.data = DATA_BITS'(write_word);
        dec.pin  = serial_in_pin;
        dec.cmd  = CMD_READ;
        if (burst_length == '0)
        begin
            dec.len = BURST_W'(1);
        end
        else if (32'(burst_length) > 32'(MAX_BURST))
        begin
            dec.len = BURST_W'(MAX_BURST);
        end
        else
        begin
            dec.len = BURST_W'(burst_length);
        end
        if (req_type)
        begin
            dec.kind = KIND_TICK;
        end
        else
        begin
            case (command)
                CMD_READ, CMD_WRITE, CMD_ERASE, CMD_ENABLE, CMD_DISABLE:
                begin
                    dec.kind = KIND_CMD;
                    dec.cmd  = cmd_t'(command);
                end
                default:
                begin
                    dec.kind = KIND_BAD;
                end
            endcase
        end
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

@@ hdl/mwe_cfg.sv @@
module mwe_cfg
    import mwe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [POLL_W-1:0] poll_limit_reg;
    logic [POLL_W-1:0] poll_limit_next;
    logic              auto_we_reg;
    logic              auto_we_next;
    logic              wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        poll_limit_next = poll_limit_reg;
        auto_we_next    = auto_we_reg;
        if (wr)
        begin
            case (paddr[2])
                REG_POLL_LIMIT: poll_limit_next = pwdata[POLL_W-1:0];
                REG_AUTO_WE:    auto_we_next    = pwdata[0];
                default:        ;
            endcase
        end
        case (paddr[2])
            REG_POLL_LIMIT: prdata = 32'(poll_limit_reg);
            REG_AUTO_WE:    prdata = 32'(auto_we_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= POLL_LIMIT_RST;
            auto_we_reg    <= 1'b1;
        end
        else
        begin
            poll_limit_reg <= poll_limit_next;
            auto_we_reg    <= auto_we_next;
        end
    end

    assign cfg.poll_limit = poll_limit_reg;
    assign cfg.auto_we    = auto_we_reg;

endmodule

@@ hdl/mwe_engine.sv @@
module mwe_engine
    import mwe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  item_valid,
    input  item_t item,
    output logic  item_take,
    input  logic  res_space,
    output logic  res_valid,
    output res_t  res
);

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [CNT_W-1:0]     bit_cnt_reg;
    logic [CNT_W-1:0]     bit_cnt_next;
    logic [FRAME_W-1:0]   shift_out_reg;
    logic [FRAME_W-1:0]   shift_out_next;
    logic [DATA_BITS-1:0] shift_in_reg;
    logic [DATA_BITS-1:0] shift_in_next;
    logic [BURST_W-1:0]   words_left_reg;
    logic [BURST_W-1:0]   words_left_next;
    logic [POLL_W-1:0]    poll_cnt_reg;
    logic [POLL_W-1:0]    poll_cnt_next;
    cmd_t                 held_cmd_reg;
    cmd_t                 held_cmd_next;
    logic [ADDR_BITS-1:0] held_addr_reg;
    logic [ADDR_BITS-1:0] held_addr_next;
    logic [DATA_BITS-1:0] held_data_reg;
    logic [DATA_BITS-1:0] held_data_next;
    logic                 timed_out_reg;
    logic                 timed_out_next;

    logic [DATA_BITS-1:0] shifted_in;
    logic [BURST_W-1:0]   words_dec;
    logic [POLL_W-1:0]    poll_inc;
    logic [POLL_W-1:0]    poll_eff;

    function automatic logic [FRAME_W-1:0] op_frame(
        input cmd_t                 cmd,
        input logic [ADDR_BITS-1:0] addr,
        input logic [DATA_BITS-1:0] data
    );
        logic [1:0]         opc;
        logic [FRAME_W-1:0] frame;
        case (cmd)
            CMD_READ:  opc = OPC_READ;
            CMD_WRITE: opc = OPC_WRITE;
            default:   opc = OPC_ERASE;
        endcase
        frame = START_BIT | (FRAME_W'(opc) << (ADDR_BITS + 1)) | FRAME_W'(addr);
        if (cmd == CMD_WRITE)
        begin
            frame = (frame << DATA_BITS) | FRAME_W'(data);
        end
        return frame;
    endfunction

    function automatic logic [CNT_W-1:0] op_count(input cmd_t cmd);
        return (cmd == CMD_WRITE) ? LONG_CNT : SHORT_CNT;
    endfunction

    assign item_take  = item_valid && res_space;
    assign shifted_in = {shift_in_reg[DATA_BITS-2:0], item.pin};
    assign words_dec  = words_left_reg - BURST_W'(words_left_reg != '0);
    assign poll_inc   = poll_cnt_reg + POLL_W'(1);
    assign poll_eff   = (cfg.poll_limit == '0) ? POLL_W'(1) : cfg.poll_limit;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        words_left_next = words_left_reg;
        poll_cnt_next   = poll_cnt_reg;
        held_cmd_next   = held_cmd_reg;
        held_addr_next  = held_addr_reg;
        held_data_next  = held_data_reg;
        timed_out_next  = timed_out_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (item_take)
        begin
            case (item.kind)
                KIND_CMD, KIND_BAD:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        res_valid  = 1'b1;
                        res.status = STAT_REJECT;
                    end
                    else if (item.kind == KIND_CMD)
                    begin
                        held_cmd_next   = item.cmd;
                        held_addr_next  = item.addr;
                        held_data_next  = item.data;
                        words_left_next = item.len;
                        timed_out_next  = 1'b0;
                        poll_cnt_next   = '0;
                        shift_in_next   = '0;
                        bit_cnt_next    = SHORT_CNT;
                        if (item.cmd == CMD_ENABLE ||
                            ((item.cmd == CMD_WRITE || item.cmd == CMD_ERASE) &&
                             cfg.auto_we))
                        begin
                            shift_out_next = EN_FRAME;
                            phase_next     = PH_EN_BITS;
                        end
                        else if (item.cmd == CMD_DISABLE)
                        begin
                            shift_out_next = DIS_FRAME;
                            phase_next     = PH_DIS_BITS;
                        end
                        else
                        begin
                            shift_out_next = op_frame(item.cmd, item.addr, item.data);
                            bit_cnt_next   = op_count(item.cmd);
                            phase_next     = PH_OP_BITS;
                        end
                    end
                end
                KIND_TICK:
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                        end
                        PH_EN_BITS, PH_OP_BITS, PH_DIS_BITS:
                        begin
                            res_valid = 1'b1;
                            res.sel   = 1'b1;
                            res.clk   = 1'b1;
                            res.di    = shift_out_reg[bit_cnt_reg];
                            if (bit_cnt_reg != '0)
                            begin
                                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                            end
                            else if (phase_reg == PH_EN_BITS)
                            begin
                                phase_next = PH_EN_GAP;
                            end
                            else if (phase_reg == PH_DIS_BITS)
                            begin
                                phase_next = PH_DONE_GAP;
                            end
                            else if (held_cmd_reg == CMD_READ)
                            begin
                                phase_next    = PH_READ;
                                bit_cnt_next  = READ_CNT;
                                shift_in_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_OP_GAP;
                            end
                        end
                        PH_EN_GAP:
                        begin
                            res_valid = 1'b1;
                            if (held_cmd_reg == CMD_ENABLE)
                            begin
                                res.done   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                shift_out_next = op_frame(held_cmd_reg, held_addr_reg,
                                                          held_data_reg);
                                bit_cnt_next   = op_count(held_cmd_reg);
                                phase_next     = PH_OP_BITS;
                            end
                        end
                        PH_READ:
                        begin
                            res_valid     = 1'b1;
                            res.sel       = 1'b1;
                            res.clk       = 1'b1;
                            shift_in_next = shifted_in;
                            if (bit_cnt_reg != '0)
                            begin
                                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                            end
                            else
                            begin
                                res.word        = shifted_in;
                                res.valid       = 1'b1;
                                words_left_next = words_dec;
                                if (words_dec == '0)
                                begin
                                    res.last   = 1'b1;
                                    phase_next = PH_DONE_GAP;
                                end
                                else
                                begin
                                    bit_cnt_next  = READ_CNT;
                                    shift_in_next = '0;
                                end
                            end
                        end
                        PH_OP_GAP:
                        begin
                            res_valid     = 1'b1;
                            poll_cnt_next = '0;
                            phase_next    = PH_POLL;
                        end
                        PH_POLL:
                        begin
                            res_valid = 1'b1;
                            res.sel   = 1'b1;
                            res.clk   = 1'b1;
                            if (item.pin)
                            begin
                                phase_next = PH_POLL_GAP;
                            end
                            else
                            begin
                                poll_cnt_next = poll_inc;
                                if (poll_inc >= poll_eff || poll_inc == '0)
                                begin
                                    timed_out_next = 1'b1;
                                    phase_next     = PH_POLL_GAP;
                                end
                            end
                        end
                        PH_POLL_GAP:
                        begin
                            res_valid = 1'b1;
                            if (cfg.auto_we)
                            begin
                                shift_out_next = DIS_FRAME;
                                bit_cnt_next   = SHORT_CNT;
                                phase_next     = PH_DIS_BITS;
                            end
                            else
                            begin
                                res.done   = 1'b1;
                                res.status = timed_out_reg ? STAT_TIMEOUT : STAT_OK;
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_DONE_GAP:
                        begin
                            res_valid  = 1'b1;
                            res.done   = 1'b1;
                            res.status = timed_out_reg ? STAT_TIMEOUT : STAT_OK;
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= '0;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            words_left_reg <= '0;
            poll_cnt_reg   <= '0;
            held_cmd_reg   <= CMD_READ;
            held_addr_reg  <= '0;
            held_data_reg  <= '0;
            timed_out_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_out_reg  <= shift_out_next;
            shift_in_reg   <= shift_in_next;
            words_left_reg <= words_left_next;
            poll_cnt_reg   <= poll_cnt_next;
            held_cmd_reg   <= held_cmd_next;
            held_addr_reg  <= held_addr_next;
            held_data_reg  <= held_data_next;
            timed_out_reg  <= timed_out_next;
        end
    end

endmodule

@@ hdl/mwe_out_q.sv @@
module mwe_out_q
    import mwe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  res_t res,
    output logic res_space,
    input  logic pop,
    output logic empty,
    output res_t head
);

    res_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_en;
    logic       rd_en;

    assign empty     = (count_reg == 2'd0);
    assign head      = q_reg[rd_ptr_reg];
    assign rd_en     = pop && !empty;
    assign res_space = (count_reg != 2'd2) || rd_en;
    assign wr_en     = res_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

@@ hdl/microwire_eeprom_master_top.sv @@
// channel   direction  handshake           payload
// -------   ---------  ------------------  ----------------------------------------------
// item      in         push / full         req_type command word_address write_word
//                                          burst_length serial_in_pin
// result    out        pop / empty         select_level serial_out_pin clock_pulse
//                                          read_word word_valid done_res status last_word
// config    in         APB psel/penable    poll_limit @0x0, auto_write_enable @0x4
//
// One word per cycle unless a queue stalls. A word is held in the front queue, and its
// result, if any, enters the result queue as the frame sequencer takes it as one step.
// Two-entry queues sit between the front end, the sequencer and the result port.
// full rises only when the front queue holds two words; a stalled pop backs up into it.
// Reset leaves the sequencer idle with both queues empty.
module microwire_eeprom_master_top
    import mwe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              req_type,
    input  logic [2:0]        command,
    input  logic [8:0]        word_address,
    input  logic [15:0]       write_word,
    input  logic [LEN_W-1:0]  burst_length,
    input  logic              serial_in_pin,
    output logic              empty,
    input  logic              pop,
    output logic              select_level,
    output logic              serial_out_pin,
    output logic              clock_pulse,
    output logic [15:0]       read_word,
    output logic              word_valid,
    output logic              done_res,
    output logic [1:0]        status,
    output logic              last_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_take;
    logic  res_valid;
    logic  res_space;
    res_t  res;
    res_t  head;

    mwe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .command       (command),
        .word_address  (word_address),
        .write_word    (write_word),
        .burst_length  (burst_length),
        .serial_in_pin (serial_in_pin),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    mwe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mwe_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_space  (res_space),
        .res_valid  (res_valid),
        .res        (res)
    );

    mwe_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_space (res_space),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    assign select_level   = head.sel;
    assign serial_out_pin = head.di;
    assign clock_pulse    = head.clk;
    assign read_word      = 16'(head.word);
    assign word_valid     = head.valid;
    assign done_res       = head.done;
    assign status         = head.status;
    assign last_word      = head.last;

endmodule
